// ----- hw/rtl/ick_pkg.sv -----
// Shared types and constants for the iambic keyer.
// No dependencies; imported by every other keyer file.
`timescale 1ns / 1ps

package ick_pkg;

    localparam int HANG_WIDTH_DEF = 16;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_KEYER_MODE   = 3'd0,
        CFG_DOT_TICKS    = 3'd1,
        CFG_DASH_TICKS   = 3'd2,
        CFG_LETTER_SPACE = 3'd3,
        CFG_HANG_TICKS   = 3'd4,
        CFG_BREAKIN      = 3'd5,
        CFG_SWAP         = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_IAMBIC_A = 2'd1;

    localparam logic [1:0]  RST_KEYER_MODE = 2'd1;
    localparam logic [11:0] RST_DOT_TICKS  = 12'd60;
    localparam logic [13:0] RST_DASH_TICKS = 14'd180;
    localparam logic [15:0] RST_HANG_TICKS = 16'd500;

    localparam logic [12:0] LETTER_MAX = 13'h1FFF;

    localparam logic [3:0] CODE_IDLE      = 4'd0;
    localparam logic [3:0] CODE_CHECK     = 4'd1;
    localparam logic [3:0] CODE_STRAIGHT  = 4'd2;
    localparam logic [3:0] CODE_PREDOT    = 4'd3;
    localparam logic [3:0] CODE_SENDDOT   = 4'd4;
    localparam logic [3:0] CODE_DOTDELAY  = 4'd5;
    localparam logic [3:0] CODE_PREDASH   = 4'd6;
    localparam logic [3:0] CODE_SENDDASH  = 4'd7;
    localparam logic [3:0] CODE_DASHDELAY = 4'd8;
    localparam logic [3:0] CODE_LETTER    = 4'd9;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_CHECK     = 10'b00_0000_0010,
        PH_STRAIGHT  = 10'b00_0000_0100,
        PH_PREDOT    = 10'b00_0000_1000,
        PH_SENDDOT   = 10'b00_0001_0000,
        PH_DOTDELAY  = 10'b00_0010_0000,
        PH_PREDASH   = 10'b00_0100_0000,
        PH_SENDDASH  = 10'b00_1000_0000,
        PH_DASHDELAY = 10'b01_0000_0000,
        PH_LETTER    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  keyer_mode;
        logic [11:0] dot_ticks;
        logic [13:0] dash_ticks;
        logic        letter_space_enable;
        logic [15:0] hang_ticks;
        logic        breakin_enable;
        logic        paddles_swapped;
    } t_cfg;

    typedef struct packed {
        logic left_level;
        logic right_level;
        logic left_hit;
        logic right_hit;
        logic tx_already_on;
    } t_tick;

    typedef struct packed {
        t_phase      phase;
        logic        dot_mem;
        logic        dash_mem;
        logic        dot_kept;
        logic        dash_kept;
        logic [13:0] mark_count;
        logic [11:0] space_count;
        logic [12:0] letter_count;
        logic        keep_ptt;
        logic        ptt;
    } t_state;

    function automatic logic [3:0] phase_code(input t_phase ph);
        logic [3:0] c;
        case (ph)
            PH_IDLE:      c = CODE_IDLE;
            PH_CHECK:     c = CODE_CHECK;
            PH_STRAIGHT:  c = CODE_STRAIGHT;
            PH_PREDOT:    c = CODE_PREDOT;
            PH_SENDDOT:   c = CODE_SENDDOT;
            PH_DOTDELAY:  c = CODE_DOTDELAY;
            PH_PREDASH:   c = CODE_PREDASH;
            PH_SENDDASH:  c = CODE_SENDDASH;
            PH_DASHDELAY: c = CODE_DASHDELAY;
            PH_LETTER:    c = CODE_LETTER;
            default:      c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/ick_cfg_regs.sv -----
// Configuration register file of the keyer.
// Depends on ick_pkg for the register index codes and the t_cfg struct.
`timescale 1ns / 1ps

module ick_cfg_regs
    import ick_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [CFG_IDX_WIDTH-1:0]  i_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keyer_mode          <= RST_KEYER_MODE;
            r_cfg.dot_ticks           <= RST_DOT_TICKS;
            r_cfg.dash_ticks          <= RST_DASH_TICKS;
            r_cfg.letter_space_enable <= 1'b0;
            r_cfg.hang_ticks          <= RST_HANG_TICKS;
            r_cfg.breakin_enable      <= 1'b1;
            r_cfg.paddles_swapped     <= 1'b0;
        end else if (i_wr) begin
            case (i_idx)
                CFG_KEYER_MODE:   r_cfg.keyer_mode          <= i_data[1:0];
                CFG_DOT_TICKS:    r_cfg.dot_ticks           <= i_data[11:0];
                CFG_DASH_TICKS:   r_cfg.dash_ticks          <= i_data[13:0];
                CFG_LETTER_SPACE: r_cfg.letter_space_enable <= i_data[0];
                CFG_HANG_TICKS:   r_cfg.hang_ticks          <= i_data[15:0];
                CFG_BREAKIN:      r_cfg.breakin_enable      <= i_data[0];
                CFG_SWAP:         r_cfg.paddles_swapped     <= i_data[0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/ick_step.sv -----
// One-tick next-state logic of the keyer sequencer: memories, counters, PTT hang.
// Depends on ick_pkg for the phase enum and the state, tick and config structs.
`timescale 1ns / 1ps

module ick_step
    import ick_pkg::*;
#(
    parameter int HANG_WIDTH = HANG_WIDTH_DEF
) (
    input  t_cfg                  i_cfg,
    input  t_tick                 i_tick,
    input  t_state                i_state,
    input  logic [HANG_WIDTH-1:0] i_hang,
    output t_state                o_state,
    output logic [HANG_WIDTH-1:0] o_hang
);

    logic                  dot;
    logic                  dash;
    logic                  dot_hit;
    logic                  dash_hit;
    logic [HANG_WIDTH-1:0] hang_load;
    logic [12:0]           letter_limit;
    t_state                s;
    logic [HANG_WIDTH-1:0] h;

    assign dot      = i_cfg.paddles_swapped ? i_tick.right_level : i_tick.left_level;
    assign dash     = i_cfg.paddles_swapped ? i_tick.left_level  : i_tick.right_level;
    assign dot_hit  = i_cfg.paddles_swapped ? i_tick.right_hit   : i_tick.left_hit;
    assign dash_hit = i_cfg.paddles_swapped ? i_tick.left_hit    : i_tick.right_hit;

    assign hang_load    = HANG_WIDTH'(i_cfg.hang_ticks);
    assign letter_limit = {i_cfg.dot_ticks, 1'b0};

    always_comb begin
        s = i_state;
        h = i_hang;

        if (dot_hit) s.dot_mem = 1'b1;
        if (dash_hit) s.dash_mem = 1'b1;

        if (s.mark_count != 14'd0) begin
            s.mark_count = s.mark_count - 14'd1;
        end else if (s.space_count != 12'd0) begin
            s.space_count = s.space_count - 12'd1;
        end

        // start of a session
        if (s.phase == PH_IDLE && h == '0 && (i_tick.left_hit || i_tick.right_hit)
                && (i_tick.left_level || i_tick.right_level)) begin
            s.keep_ptt = i_tick.tx_already_on;
            h          = '0;
            if (i_cfg.breakin_enable) begin
                s.ptt = 1'b1;
                h     = hang_load;
            end
            s.phase = PH_CHECK;
        end

        if (s.phase != PH_IDLE || h != '0) begin
            if (h != '0 && s.phase != PH_IDLE && s.phase != PH_CHECK) h = hang_load;
            case (s.phase)
                PH_IDLE: begin
                    h = h - HANG_WIDTH'(1);
                    if (h == '0) begin
                        if (!s.keep_ptt) s.ptt = 1'b0;
                    end else begin
                        s.phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    s.phase = PH_IDLE;
                    if (h > HANG_WIDTH'(1)) h = h - HANG_WIDTH'(1);
                    if (i_cfg.keyer_mode == MODE_STRAIGHT) begin
                        if (dot) s.phase = PH_PREDOT;
                        if (dash) begin
                            s.mark_count  = '0;
                            s.space_count = '0;
                            s.phase       = PH_STRAIGHT;
                        end
                    end else begin
                        if (dash) s.phase = PH_PREDASH;
                        if (dot) s.phase = PH_PREDOT;
                    end
                end
                PH_STRAIGHT: begin
                    if (!dash) begin
                        s.mark_count  = '0;
                        s.space_count = '0;
                        s.phase       = PH_CHECK;
                    end
                end
                PH_PREDOT: begin
                    s.dash_mem    = 1'b0;
                    s.dash_kept   = dash;
                    s.mark_count  = 14'(i_cfg.dot_ticks);
                    s.space_count = i_cfg.dot_ticks;
                    s.phase       = PH_SENDDOT;
                end
                PH_SENDDOT: begin
                    if (s.mark_count == 14'd0) s.phase = PH_DOTDELAY;
                end
                PH_DOTDELAY: begin
                    if (s.space_count == 12'd0) begin
                        if (i_cfg.keyer_mode == MODE_STRAIGHT) begin
                            s.phase = dot ? PH_PREDOT : PH_IDLE;
                        end else begin
                            if (i_cfg.keyer_mode == MODE_IAMBIC_A && !dot && !dash)
                                s.dash_kept = 1'b0;
                            if (s.dash_mem || dash || s.dash_kept) begin
                                s.phase = PH_PREDASH;
                            end else if (dot) begin
                                s.phase = PH_PREDOT;
                            end else if (i_cfg.letter_space_enable) begin
                                s.dot_mem      = 1'b0;
                                s.dash_mem     = 1'b0;
                                s.letter_count = '0;
                                s.phase        = PH_LETTER;
                            end else begin
                                s.phase = PH_IDLE;
                            end
                        end
                    end
                end
                PH_PREDASH: begin
                    s.dot_mem     = 1'b0;
                    s.dot_kept    = dot;
                    s.mark_count  = i_cfg.dash_ticks;
                    s.space_count = i_cfg.dot_ticks;
                    s.phase       = PH_SENDDASH;
                end
                PH_SENDDASH: begin
                    if (s.mark_count == 14'd0) s.phase = PH_DASHDELAY;
                end
                PH_DASHDELAY: begin
                    if (s.space_count == 12'd0) begin
                        if (i_cfg.keyer_mode == MODE_IAMBIC_A && !dot && !dash)
                            s.dot_kept = 1'b0;
                        if (s.dot_mem || dot || s.dot_kept) begin
                            s.phase = PH_PREDOT;
                        end else if (dash) begin
                            s.phase = PH_PREDASH;
                        end else if (i_cfg.letter_space_enable) begin
                            s.dot_mem      = 1'b0;
                            s.dash_mem     = 1'b0;
                            s.letter_count = '0;
                            s.phase        = PH_LETTER;
                        end else begin
                            s.phase = PH_IDLE;
                        end
                    end
                end
                PH_LETTER: begin
                    if (s.letter_count < LETTER_MAX) s.letter_count = s.letter_count + 13'd1;
                    if (s.letter_count > letter_limit) begin
                        if (s.dot_mem) s.phase = PH_PREDOT;
                        else if (s.dash_mem) s.phase = PH_PREDASH;
                        else s.phase = PH_IDLE;
                    end
                end
                default: s.phase = PH_IDLE;
            endcase
        end

        o_state = s;
        o_hang  = h;
    end

endmodule

// ----- hw/rtl/iambic_cw_keyer_top.sv -----
// Top level of the iambic keyer: tick input register, sequencer state, result register.
// Depends on ick_pkg, ick_cfg_regs and ick_step.
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_stall) takes one timing tick per transfer: paddle
// levels, paddle hits seen during the tick, and the transmitter-on flag.
// Output channel (o_out_valid / i_out_stall) gives one result per tick: key state,
// break-in PTT state and sequencer phase (0 idle .. 9 letter space).
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes one register
// per transfer: 0 mode, 1 dot ticks, 2 dash ticks, 3 letter space enable, 4 hang ticks,
// 5 break-in enable, 6 paddle swap. Other indexes are ignored. Write only while idle.
// An accepted tick passes through the input register, then the result register, before
// its result is on the output. Throughput: one tick per cycle while the receiver does
// not stall, set by the combinational sequencer step between the two registers.
// When the receiver stalls, the result register holds and the input register can
// still take one more tick; the input channel stalls only when both are full.
// Reset (synchronous, active low) empties both registers, puts the sequencer in idle
// with all memories, counters and PTT cleared, and loads the default configuration.

module iambic_cw_keyer_top
    import ick_pkg::*;
#(
    parameter int HANG_WIDTH = HANG_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_left_level,
    input  logic                      i_right_level,
    input  logic                      i_left_hit,
    input  logic                      i_right_hit,
    input  logic                      i_tx_already_on,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_key_on,
    output logic                      o_ptt_on,
    output logic [3:0]                o_keyer_phase,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    t_cfg                  cfg;
    logic                  r_in_valid;
    t_tick                 r_tick;
    t_state                r_state;
    t_state                n_state;
    logic [HANG_WIDTH-1:0] r_hang;
    logic [HANG_WIDTH-1:0] n_hang;
    logic                  r_out_valid;
    logic                  r_key_on;
    logic                  r_ptt_on;
    logic [3:0]            r_phase_code;
    logic                  advance;

    assign o_cfg_ready = 1'b1;

    ick_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ick_step #(
        .HANG_WIDTH (HANG_WIDTH)
    ) u_step (
        .i_cfg   (cfg),
        .i_tick  (r_tick),
        .i_state (r_state),
        .i_hang  (r_hang),
        .o_state (n_state),
        .o_hang  (n_hang)
    );

    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_tick.left_level    <= i_left_level;
            r_tick.right_level   <= i_right_level;
            r_tick.left_hit      <= i_left_hit;
            r_tick.right_hit     <= i_right_hit;
            r_tick.tx_already_on <= i_tx_already_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.dot_mem      <= 1'b0;
            r_state.dash_mem     <= 1'b0;
            r_state.dot_kept     <= 1'b0;
            r_state.dash_kept    <= 1'b0;
            r_state.mark_count   <= '0;
            r_state.space_count  <= '0;
            r_state.letter_count <= '0;
            r_state.keep_ptt     <= 1'b0;
            r_state.ptt          <= 1'b0;
            r_hang               <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_hang  <= n_hang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_key_on     <= (n_state.phase == PH_SENDDOT) || (n_state.phase == PH_SENDDASH)
                            || (n_state.phase == PH_STRAIGHT);
            r_ptt_on     <= n_state.ptt;
            r_phase_code <= phase_code(n_state.phase);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_on      = r_key_on;
    assign o_ptt_on      = r_ptt_on;
    assign o_keyer_phase = r_phase_code;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.phase))
        else $error("sequencer phase not one-hot");

    a_straight_no_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_STRAIGHT |-> r_state.mark_count == '0
            && r_state.space_count == '0)
        else $error("element timers running in straight key phase");

    a_key_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_on |-> o_keyer_phase == CODE_SENDDOT
            || o_keyer_phase == CODE_SENDDASH || o_keyer_phase == CODE_STRAIGHT)
        else $error("key on outside a sending phase");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> $stable(r_state.phase)
            && $stable(r_hang))
        else $error("sequencer advanced while result was stalled");

endmodule
